// ===== design/length_crc32_frame_receiver_assert.svh =====
// Assertion macros for the length-prefixed CRC-32 frame receiver.
`ifndef LENGTH_CRC32_FRAME_RECEIVER_ASSERT_SVH
`define LENGTH_CRC32_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LCFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LCFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lcfr_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the frame receiver.
`default_nettype none

package lcfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CrcW   = 32;
  localparam int unsigned ApbW   = 32;
  localparam int unsigned PaddrW = 2;

  localparam logic [CrcW-1:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [CrcW-1:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [LenW-1:0] MAX_LEN_RESET = 16'd1024;
  localparam logic [LenW-1:0] CRC_BYTES     = 16'd4;

  typedef enum logic [1:0] {
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CRC
  } phase_e;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_OK      = 2'd1,
    ST_CRC_ERR = 2'd2,
    ST_LEN_ERR = 2'd3
  } status_e;

  typedef struct packed {
    logic            data_valid;
    logic [ByteW-1:0] data_byte;
    logic [LenW-1:0] data_index;
    logic            frame_end;
    logic [1:0]      frame_status;
    logic [LenW-1:0] frame_length;
  } res_t;

  typedef struct packed {
    logic out_valid;
    logic skid_valid;
  } skid_stat_t;

  // Reflected CRC-32, one byte unrolled over eight bit steps.
  function automatic logic [CrcW-1:0] crc32_byte(input logic [CrcW-1:0] crc_in,
                                                 input logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc_in ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int i = 0; i < ByteW; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/lcfr_if.sv =====
// Stream interfaces for received bytes and per-byte results.
`default_nettype none

interface lcfr_rx_if;
  import lcfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lcfr_res_if;
  import lcfr_pkg::*;
  logic             valid;
  logic             ready;
  logic             data_valid;
  logic [ByteW-1:0] data_byte;
  logic [LenW-1:0]  data_index;
  logic             frame_end;
  logic [1:0]       frame_status;
  logic [LenW-1:0]  frame_length;

  modport source (output valid, output data_valid, output data_byte, output data_index,
                  output frame_end, output frame_status, output frame_length,
                  input ready);
  modport sink   (input valid, input data_valid, input data_byte, input data_index,
                  input frame_end, input frame_status, input frame_length,
                  output ready);
endinterface

`default_nettype wire

// ===== design/lcfr_cfg_regs.sv =====
// APB register file holding the maximum payload length.
`default_nettype none

module lcfr_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcfr_pkg::PaddrW-1:0] paddr,
  input  logic [lcfr_pkg::ApbW-1:0]   pwdata,
  output logic [lcfr_pkg::ApbW-1:0]   prdata,
  output logic                        pready,
  output logic [lcfr_pkg::LenW-1:0]   max_len_o
);
  import lcfr_pkg::*;

  logic [LenW-1:0] max_len_q;
  logic [LenW-1:0] max_len_d;
  logic            wr_en;

  // Single register: paddr is ignored entirely, so every address maps to it.
  assign wr_en     = psel & penable & pwrite;
  assign pready    = 1'b1;
  assign max_len_d = wr_en ? pwdata[LenW-1:0] : max_len_q;
  assign prdata    = {{(ApbW-LenW){1'b0}}, max_len_q} & {ApbW{paddr == '0 || paddr != '0}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  assign max_len_o = max_len_q;

endmodule

`default_nettype wire

// ===== design/lcfr_deframer.sv =====
// Frame parser: length, payload pass-through, CRC-32 check, one result per byte.
`default_nettype none

module lcfr_deframer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [lcfr_pkg::ByteW-1:0] rx_byte_i,
  input  logic [lcfr_pkg::LenW-1:0]  max_len_i,
  output lcfr_pkg::res_t             res_o
);
  import lcfr_pkg::*;

  phase_e           phase_q, phase_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [CrcW-1:0]  crc_q, crc_d;
  logic             mis_q, mis_d;

  logic [LenW-1:0]  cnt_inc;
  logic [LenW-1:0]  new_len;
  logic [CrcW-1:0]  final_crc;
  logic [ByteW-1:0] expect_byte;
  logic             mis_new;
  res_t             res;

  assign cnt_inc   = cnt_q + LenW'(1);
  assign new_len   = {len_q[ByteW-1:0], rx_byte_i};
  assign final_crc = ~crc_q;

  // CRC goes out most significant byte first.
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    expect_byte = final_crc[31:24];
      2'd1:    expect_byte = final_crc[23:16];
      2'd2:    expect_byte = final_crc[15:8];
      default: expect_byte = final_crc[7:0];
    endcase
  end

  assign mis_new = mis_q | (expect_byte != rx_byte_i);

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    mis_d   = mis_q;
    res     = '0;
    unique case (phase_q)
      PH_LEN_HI: begin
        len_d   = {{(LenW-ByteW){1'b0}}, rx_byte_i};
        cnt_d   = '0;
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d            = new_len;
        res.frame_length = new_len;
        cnt_d            = '0;
        crc_d            = CRC_INIT;
        mis_d            = 1'b0;
        if (new_len > max_len_i) begin
          res.frame_end    = 1'b1;
          res.frame_status = ST_LEN_ERR;
          phase_d          = PH_LEN_HI;
        end else if (new_len == '0) begin
          // empty payload: go straight to the CRC bytes
          phase_d = PH_CRC;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.frame_length = len_q;
        res.data_valid   = 1'b1;
        res.data_byte    = rx_byte_i;
        res.data_index   = cnt_q;
        crc_d            = crc32_byte(crc_q, rx_byte_i);
        cnt_d            = cnt_inc;
        if (cnt_inc >= len_q) begin
          cnt_d   = '0;
          phase_d = PH_CRC;
        end
      end
      PH_CRC: begin
        res.frame_length = len_q;
        mis_d            = mis_new;
        cnt_d            = cnt_inc;
        if (cnt_inc >= CRC_BYTES) begin
          res.frame_end    = 1'b1;
          res.frame_status = mis_new ? ST_CRC_ERR : ST_OK;
          phase_d          = PH_LEN_HI;
          cnt_d            = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN_HI;
      len_q   <= '0;
      cnt_q   <= '0;
      crc_q   <= CRC_INIT;
      mis_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      mis_q   <= mis_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

// ===== design/lcfr_out_skid.sv =====
// Result register with a skid stage so input can still push one word while output stalls.
`default_nettype none

module lcfr_out_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lcfr_pkg::res_t       push_data_i,
  input  logic                 pop_ready_i,
  output lcfr_pkg::res_t       data_o,
  output logic                 ready_o,
  output lcfr_pkg::skid_stat_t stat_o
);
  import lcfr_pkg::*;

  logic ov_q, ov_d;
  logic sv_q, sv_d;
  res_t od_q, od_d;
  res_t sd_q, sd_d;
  logic pop;

  assign pop     = ov_q & pop_ready_i;
  assign ready_o = ~sv_q;

  always_comb begin
    ov_d = ov_q;
    sv_d = sv_q;
    od_d = od_q;
    sd_d = sd_q;
    if (pop) begin
      if (sv_q) begin
        // drain the skid word into the output register
        od_d = sd_q;
        sv_d = 1'b0;
      end else if (push_i) begin
        od_d = push_data_i;
      end else begin
        ov_d = 1'b0;
      end
    end else if (push_i) begin
      if (!ov_q) begin
        od_d = push_data_i;
        ov_d = 1'b1;
      end else begin
        // output stalled: park the word
        sd_d = push_data_i;
        sv_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
    sd_q <= sd_d;
  end

  assign data_o            = od_q;
  assign stat_o.out_valid  = ov_q;
  assign stat_o.skid_valid = sv_q;

endmodule

`default_nettype wire

// ===== design/length_crc32_frame_receiver.sv =====
// Top level of the length-prefixed CRC-32 frame receiver.
// Result words are registered in the output register, or parked in the skid register while output stalls.
// Throughput: one byte per cycle while the skid register is empty; the CRC update is an unrolled 8-bit step.
// Reset: asynchronous, waits for a length high byte, max payload length 1024.
`default_nettype none

`include "length_crc32_frame_receiver_assert.svh"

module length_crc32_frame_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lcfr_rx_if.sink                     rx_i,
  lcfr_res_if.source                  res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcfr_pkg::PaddrW-1:0] paddr,
  input  logic [lcfr_pkg::ApbW-1:0]   pwdata,
  output logic [lcfr_pkg::ApbW-1:0]   prdata,
  output logic                        pready
);
  import lcfr_pkg::*;

  logic            accept;
  logic            skid_ready;
  logic [LenW-1:0] max_len;
  res_t            step_res;
  res_t            out_res;
  skid_stat_t      skid_stat;

  assign rx_i.ready = skid_ready;
  assign accept     = rx_i.valid & skid_ready;

  lcfr_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  lcfr_deframer u_deframer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_i.rx_byte),
    .max_len_i (max_len),
    .res_o     (step_res)
  );

  lcfr_out_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (step_res),
    .pop_ready_i (res_o.ready),
    .data_o      (out_res),
    .ready_o     (skid_ready),
    .stat_o      (skid_stat)
  );

  assign res_o.valid        = skid_stat.out_valid;
  assign res_o.data_valid   = out_res.data_valid;
  assign res_o.data_byte    = out_res.data_byte;
  assign res_o.data_index   = out_res.data_index;
  assign res_o.frame_end    = out_res.frame_end;
  assign res_o.frame_status = out_res.frame_status;
  assign res_o.frame_length = out_res.frame_length;

  `LCFR_ASSERT_NOW(a_skid_implies_out, skid_stat.skid_valid, skid_stat.out_valid, "skid word without output word")
  `LCFR_ASSERT_NEXT(a_stall_parks_word, accept && skid_stat.out_valid && !res_o.ready, skid_stat.skid_valid, "stalled word not parked")
  `LCFR_ASSERT_NOW(a_status_only_at_end, res_o.valid && !res_o.frame_end, res_o.frame_status == ST_NONE, "status without frame end")
  `LCFR_ASSERT_NOW(a_index_in_frame, res_o.valid && res_o.data_valid, res_o.data_index < res_o.frame_length, "payload index beyond length")

endmodule

`default_nettype wire
